### rtl/core/f2d_pkg.sv
package f2d_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SCALE,
        ST_DIV,
        ST_FIN
    } f2d_state_t;

    typedef enum logic [1:0] {
        STAT_NORMAL  = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_POS_OVF = 2'd2,
        STAT_NEG_OVF = 2'd3
    } f2d_status_t;

    localparam logic [30:0] MAG_OVF_BITS = 31'h509502F9;
    localparam logic [30:0] MAG_INF_BITS = 31'h7F800000;
    localparam logic [23:0] POS_OVF_MANT = 24'h0007FE;
    localparam logic [23:0] NEG_OVF_MANT = 24'h000802;
    localparam logic [23:0] LIMIT_SIG    = 24'hFFE000;
    localparam logic signed [8:0] LIMIT_EXP = 9'sd10;
    localparam int DIV_STEPS = 8;

    // true when sig*2^(e-23) lies below 2047
    function automatic logic below_limit(input logic [23:0] sig, input logic signed [8:0] e);
        below_limit = (e < LIMIT_EXP) || ((e == LIMIT_EXP) && (sig < LIMIT_SIG));
    endfunction

    function automatic logic above_limit(input logic [23:0] sig, input logic signed [8:0] e);
        above_limit = (e > LIMIT_EXP) || ((e == LIMIT_EXP) && (sig > LIMIT_SIG));
    endfunction

endpackage

### rtl/core/f2d_scale_unit.sv
module f2d_scale_unit
    import f2d_pkg::*;
(
    input  logic              is_div,
    input  logic [23:0]       sig,
    input  logic signed [8:0] e,
    input  logic [27:0]       quot,
    input  logic              rem_nz,
    output logic [23:0]       sig_out,
    output logic signed [8:0] e_out
);
    logic [27:0]       p;
    logic [23:0]       base;
    logic              g;
    logic              s;
    logic signed [8:0] ne;
    logic [24:0]       sum;

    // shared normalize and round-to-nearest-even for both scaling steps
    // a divide hands in floor(sig*2^7/10), a multiply forms sig*10 here
    always_comb
    begin
        if (is_div)
        begin
            p = quot;
        end
        else
        begin
            p = {4'd0, sig} * 28'd10;
        end
        if (p[27])
        begin
            base = p[27:4];
            g    = p[3];
            s    = (|p[2:0]) | (is_div & rem_nz);
            ne   = is_div ? e - 9'sd3 : e + 9'sd4;
        end
        else
        begin
            base = p[26:3];
            g    = p[2];
            s    = (|p[1:0]) | (is_div & rem_nz);
            ne   = is_div ? e - 9'sd4 : e + 9'sd3;
        end
        sum = {1'b0, base} + {24'd0, g & (s | base[0])};
        if (sum[24])
        begin
            sig_out = sum[24:1];
            e_out   = ne + 9'sd1;
        end
        else
        begin
            sig_out = sum[23:0];
            e_out   = ne;
        end
    end
endmodule

### rtl/core/float32_to_decimal_float_encoder.sv
// float32 to base-10 float encoder
// input channel: float_bits with in_valid / in_stall; a transfer happens on a
// rising edge with in_valid high and in_stall low
// output channel: dec_exponent, dec_mantissa, packed_word, status_code with
// out_valid / out_stall; one result per input, held steady while stalled
// zero, nan and out-of-range inputs get their result registered on the transfer edge
// other values are scaled on one shared multiply-by-10 / divide-by-10 unit:
// a divide: setup in the scale state, then 8 nibble steps, rounded on the last;
// a multiply is done in the scale state itself; the finish state then writes
// out the result; subnormal inputs first take one-bit normalize shifts
// the block takes one item at a time: in_stall is high while an item is in
// work or while a finished result waits on out_stall
// reset clears the sequencer and the output valid; no clearing pass
module float32_to_decimal_float_encoder
    import f2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] float_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [7:0]  dec_exponent,
    output logic signed [23:0] dec_mantissa,
    output logic [31:0] packed_word,
    output logic [1:0]  status_code
);
    f2d_state_t        state_reg, state_next;
    logic [23:0]       sig_reg, sig_next;
    logic signed [8:0] e_reg, e_next;
    logic signed [7:0] expo_reg, expo_next;
    logic              neg_reg, neg_next;
    logic [31:0]       num_reg, num_next;
    logic [27:0]       quot_reg, quot_next;
    logic [3:0]        rem_reg, rem_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [7:0] oexp_reg, oexp_next;
    logic [23:0]       omant_reg, omant_next;
    logic [1:0]        ostat_reg, ostat_next;

    logic              out_free;
    logic              in_xfer;
    logic [30:0]       magbits;
    logic [23:0]       unit_sig;
    logic signed [8:0] unit_e;
    logic              unit_div;
    logic [7:0]        dv;
    logic [15:0]       dmul;
    logic [3:0]        dq;
    logic [4:0]        shamt;
    logic [23:0]       mag_int;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign magbits  = float_bits[30:0];
    assign unit_div = (state_reg == ST_DIV);

    f2d_scale_unit u_scale (
        .is_div  (unit_div),
        .sig     (sig_reg),
        .e       (e_reg),
        .quot    (quot_next),
        .rem_nz  (rem_next != 4'd0),
        .sig_out (unit_sig),
        .e_out   (unit_e)
    );

    // one quotient digit of a divide by ten: v*205>>11 is exact for v below 1029
    assign dv    = {rem_reg, num_reg[31:28]};
    assign dmul  = {8'd0, dv} * 16'd205;
    assign dq    = dmul[14:11];
    assign shamt = 5'd23 - e_reg[4:0];
    assign mag_int = sig_reg >> shamt;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && magbits != 31'd0 && magbits <= MAG_OVF_BITS)
                begin
                    state_next = (magbits[30:23] == 8'd0) ? ST_NORM : ST_SCALE;
                end
            end
            ST_NORM:
            begin
                if (sig_reg[23])
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (above_limit(sig_reg, e_reg))
                begin
                    state_next = ST_DIV;
                end
                else if (!below_limit(unit_sig, unit_e))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 3'(DIV_STEPS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sig_next       = sig_reg;
        e_next         = e_reg;
        expo_next      = expo_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        oexp_next      = oexp_reg;
        omant_next     = omant_reg;
        ostat_next     = ostat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next  = float_bits[31];
                    expo_next = 8'sd0;
                    if (magbits[30:23] == 8'd0)
                    begin
                        sig_next = {1'b0, magbits[22:0]};
                        e_next   = -9'sd126;
                    end
                    else
                    begin
                        sig_next = {1'b1, magbits[22:0]};
                        e_next   = $signed({1'b0, magbits[30:23]}) - 9'sd127;
                    end
                    if (magbits == 31'd0)
                    begin
                        out_valid_next = 1'b1;
                        oexp_next      = 8'sd0;
                        omant_next     = 24'd0;
                        ostat_next     = STAT_ZERO;
                    end
                    else if (magbits > MAG_INF_BITS)
                    begin
                        out_valid_next = 1'b1;
                        oexp_next      = 8'sd0;
                        omant_next     = POS_OVF_MANT;
                        ostat_next     = STAT_POS_OVF;
                    end
                    else if (magbits > MAG_OVF_BITS)
                    begin
                        out_valid_next = 1'b1;
                        oexp_next      = 8'sd0;
                        omant_next     = float_bits[31] ? NEG_OVF_MANT : POS_OVF_MANT;
                        ostat_next     = float_bits[31] ? STAT_NEG_OVF : STAT_POS_OVF;
                    end
                end
            end
            ST_NORM:
            begin
                if (!sig_reg[23])
                begin
                    sig_next = {sig_reg[22:0], 1'b0};
                    e_next   = e_reg - 9'sd1;
                end
            end
            ST_SCALE:
            begin
                if (above_limit(sig_reg, e_reg))
                begin
                    // dividend sig*2^7, leading quotient nibble zero
                    num_next  = {1'b0, sig_reg, 7'd0};
                    quot_next = 28'd0;
                    rem_next  = 4'd0;
                    cnt_next  = 3'd0;
                end
                else if (below_limit(unit_sig, unit_e))
                begin
                    sig_next  = unit_sig;
                    e_next    = unit_e;
                    expo_next = expo_reg - 8'sd1;
                end
            end
            ST_DIV:
            begin
                quot_next = {quot_reg[23:0], dq};
                rem_next  = 4'(dv - 8'(dq) * 8'd10);
                num_next  = {num_reg[27:0], 4'd0};
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'(DIV_STEPS - 1))
                begin
                    sig_next  = unit_sig;
                    e_next    = unit_e;
                    expo_next = expo_reg + 8'sd1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    oexp_next      = expo_reg;
                    omant_next     = neg_reg ? 24'd0 - mag_int : mag_int;
                    ostat_next     = STAT_NORMAL;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig_reg   <= sig_next;
        e_reg     <= e_next;
        expo_reg  <= expo_next;
        neg_reg   <= neg_next;
        num_reg   <= num_next;
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        oexp_reg  <= oexp_next;
        omant_reg <= omant_next;
        ostat_reg <= ostat_next;
    end

    assign out_valid    = out_valid_reg;
    assign dec_exponent = oexp_reg;
    assign dec_mantissa = omant_reg;
    assign packed_word  = {oexp_reg, omant_reg};
    assign status_code  = ostat_reg;
endmodule
